### rtl/core/itoa_pkg.sv
// itoa_pkg: shared types and character codes for the decimal text converter.
// No dependencies.
`timescale 1ns / 1ps

package itoa_pkg;

    typedef logic [5:0] char_t;
    typedef logic [3:0] bcd_digit_t;

    // Status handed from the converter to the character sequencer
    typedef struct packed {
        logic done;     // one-cycle pulse, BCD result valid
        logic neg;      // value was negative
    } dab_stat_t;

    localparam char_t      CHAR_MINUS = 6'd45;
    localparam char_t      CHAR_ZERO  = 6'd48;
    localparam bcd_digit_t BCD_LIMIT  = 4'd5;   // add-3 threshold
    localparam bcd_digit_t BCD_ADJ    = 4'd3;

endpackage

### rtl/core/itoa_dabble.sv
// itoa_dabble: iterative shift-and-add-3 binary to BCD converter, one bit a cycle.
// Depends on itoa_pkg.
`timescale 1ns / 1ps

module itoa_dabble #(
    parameter int VALUE_BITS = 32,
    parameter int NDIG       = 10
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [VALUE_BITS-1:0]   value,
    output logic                    busy,
    output itoa_pkg::dab_stat_t     stat,
    output logic [NDIG*4-1:0]       bcd
);
    import itoa_pkg::*;

    localparam int CW = $clog2(VALUE_BITS);

    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic [NDIG*4-1:0]     bcd_reg, bcd_next, bcd_adj;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic                  neg_reg, neg_next;
    logic                  neg_in;

    assign neg_in = value[VALUE_BITS-1];

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int d = 0; d < NDIG; d++) begin
            if (bcd_reg[d*4 +: 4] >= BCD_LIMIT) begin
                bcd_adj[d*4 +: 4] = bcd_reg[d*4 +: 4] + BCD_ADJ;
            end else begin
                bcd_adj[d*4 +: 4] = bcd_reg[d*4 +: 4];
            end
        end
    end

    always_comb begin
        mag_next  = mag_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        if (start) begin
            // magnitude of the most negative value fits as unsigned
            mag_next  = neg_in ? (~value + 1'b1) : value;
            bcd_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
            neg_next  = neg_in;
        end else if (busy_reg) begin
            {bcd_next, mag_next} = {bcd_adj[NDIG*4-2:0], mag_reg, 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(VALUE_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
    end

    assign busy      = busy_reg;
    assign stat.done = done_reg;
    assign stat.neg  = neg_reg;
    assign bcd       = bcd_reg;

endmodule

### rtl/core/itoa_emit.sv
// itoa_emit: character sequencer; skips leading zeros, emits sign and digits
// through a registered output stage. Depends on itoa_pkg.
`timescale 1ns / 1ps

module itoa_emit #(
    parameter int NDIG = 10
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  itoa_pkg::dab_stat_t     stat,
    input  logic [NDIG*4-1:0]       bcd,
    output logic                    busy,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output itoa_pkg::char_t         m_char,
    output logic                    m_tlast
);
    import itoa_pkg::*;

    localparam int RW = $clog2(NDIG + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SKIP = 2'd1;
    localparam logic [1:0] ST_SIGN = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [NDIG*4-1:0]  dig_reg, dig_next;
    logic [RW-1:0]      rem_reg, rem_next;
    logic               neg_reg, neg_next;
    logic               vld_reg, vld_next;
    char_t              chr_reg, chr_next;
    logic               lst_reg, lst_next;
    logic               out_free;
    bcd_digit_t         top_dig;

    assign out_free = !vld_reg || m_tready;
    assign top_dig  = dig_reg[NDIG*4-1 -: 4];

    always_comb begin
        state_next = state_reg;
        dig_next   = dig_reg;
        rem_next   = rem_reg;
        neg_next   = neg_reg;
        vld_next   = vld_reg && !m_tready;
        chr_next   = chr_reg;
        lst_next   = lst_reg;
        case (state_reg)
            ST_IDLE: begin
                if (stat.done) begin
                    dig_next   = bcd;
                    rem_next   = RW'(NDIG);
                    neg_next   = stat.neg;
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                // drop one leading zero a cycle, keep at least one digit
                if (top_dig == '0 && rem_reg != RW'(1)) begin
                    dig_next = {dig_reg[NDIG*4-5:0], 4'b0000};
                    rem_next = rem_reg - 1'b1;
                end else begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    vld_next   = 1'b1;
                    chr_next   = CHAR_MINUS;
                    lst_next   = 1'b0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    vld_next = 1'b1;
                    chr_next = CHAR_ZERO + {2'b00, top_dig};
                    lst_next = (rem_reg == RW'(1));
                    dig_next = {dig_reg[NDIG*4-5:0], 4'b0000};
                    rem_next = rem_reg - 1'b1;
                    if (rem_reg == RW'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            vld_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            vld_reg   <= vld_next;
        end
        dig_reg <= dig_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
        chr_reg <= chr_next;
        lst_reg <= lst_next;
    end

    assign busy     = (state_reg != ST_IDLE);
    assign m_tvalid = vld_reg;
    assign m_char   = chr_reg;
    assign m_tlast  = lst_reg;

endmodule

### rtl/core/signed_int_to_decimal_ascii.sv
// signed_int_to_decimal_ascii: top level, signed integer to decimal ASCII text.
// Depends on itoa_pkg, itoa_dabble and itoa_emit.
`timescale 1ns / 1ps
//
// Usage
//   Slave channel (s_): one beat carries one two's complement integer; bits of
//   s_tdata above VALUE_BITS are ignored. Master channel (m_): one beat per
//   character, most significant first: '-' for a negative value, then the
//   digits without leading zeros ('0' for zero). m_tlast marks the final
//   character of each number.
//   Timing: a beat is followed by the shift-add-3 loop in the BCD unit, one
//   bit a cycle, a handover to the sequencer, one cycle per skipped leading
//   zero (up to NDIG-1), a decision step, then one character a cycle while
//   the sink takes them.
//   s_tready is low from the accepted beat until the last character of that
//   number has entered the output register, so one number is in flight.
//   Reset (aresetn low, synchronous) drops all valids and returns to idle.
//   A stalled sink (m_tready low) holds the output register; the sequencer
//   waits and the character text is never lost or repeated.
//

module signed_int_to_decimal_ascii #(
    parameter int VALUE_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [5:0] ascii_char, [7:6] zero
    output logic        m_tlast     // last_char
);
    import itoa_pkg::*;

    // decimal digits needed for 2^VALUE_BITS - 1 (log10(2) ~ 1233/4096)
    localparam int NDIG = ((VALUE_BITS * 1233) >> 12) + 1;

    logic [VALUE_BITS+31:0] in_ext;
    logic [VALUE_BITS-1:0]  value_in;
    logic                   start;
    logic                   dab_busy;
    logic                   emit_busy;
    dab_stat_t              dab_stat;
    logic [NDIG*4-1:0]      bcd;
    char_t                  m_char;

    // fit the 32-bit beat to the working width (zero fill above 32 bits)
    assign in_ext   = {{VALUE_BITS{1'b0}}, s_tdata};
    assign value_in = in_ext[VALUE_BITS-1:0];

    // idle only when neither unit holds a number nor the handover is pending
    assign s_tready = !dab_busy && !dab_stat.done && !emit_busy;
    assign start    = s_tvalid && s_tready;

    itoa_dabble #(
        .VALUE_BITS (VALUE_BITS),
        .NDIG       (NDIG)
    ) u_dabble (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .value   (value_in),
        .busy    (dab_busy),
        .stat    (dab_stat),
        .bcd     (bcd)
    );

    itoa_emit #(
        .NDIG (NDIG)
    ) u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .stat     (dab_stat),
        .bcd      (bcd),
        .busy     (emit_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_char   (m_char),
        .m_tlast  (m_tlast)
    );

    assign m_tdata = {2'b00, m_char};

`ifndef SYNTHESIS
    // an accepted beat starts the converter straight away
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> dab_busy)
        else $error("converter not started after accepted beat");

    // converter and sequencer never hold a number at the same time
    a_one_number: assert property (@(posedge aclk) disable iff (!aresetn)
        !(dab_busy && emit_busy))
        else $error("converter and sequencer both busy");

    // handover pulse only after the converter has run and meets an idle sequencer
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        dab_stat.done |-> ($past(dab_busy) && !emit_busy))
        else $error("BCD handover out of sequence");

    // handover pulse is a single cycle
    a_done_single: assert property (@(posedge aclk) disable iff (!aresetn)
        dab_stat.done |=> !dab_stat.done)
        else $error("BCD handover held for more than one cycle");
`endif

endmodule

### tb/tb.sv
// tb: self-checking bench for signed_int_to_decimal_ascii, integer in, decimal ASCII text out.
// Depends on itoa_pkg and the signed_int_to_decimal_ascii RTL; needs no other files.
`timescale 1ns / 1ps

module tb;

    import itoa_pkg::*;

    // Expected text store: each accepted integer is spelt out here as the
    // characters the block should send, oldest first.
    class decimal_text_board;
        typedef struct {
            char_t code;
            logic  last;
        } text_beat_t;

        text_beat_t pending_chars[$];
        int         mismatches;

        // Spell one integer: '-' if negative, then magnitude digits, MS first.
        function void note_value(logic [31:0] raw);
            bit [31:0]  mag;
            int         digit_q[$];
            text_beat_t beat;
            // two's complement magnitude; 32 bits unsigned holds 2^31 exactly
            mag = raw[31] ? (~raw + 32'd1) : raw;
            do begin
                digit_q.push_front(int'(mag % 10));
                mag = mag / 10;
            end while (mag != 0);
            if (raw[31]) begin
                beat.code = CHAR_MINUS;
                beat.last = 1'b0;
                pending_chars.push_back(beat);
            end
            foreach (digit_q[i]) begin
                beat.code = CHAR_ZERO + char_t'(digit_q[i]);
                beat.last = (i == digit_q.size() - 1);
                pending_chars.push_back(beat);
            end
        endfunction

        function void check_char(logic [7:0] data, logic last);
            text_beat_t want;
            if (pending_chars.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected char beat data=%0d last=%b", $realtime, data, last);
                return;
            end
            want = pending_chars.pop_front();
            if (data !== {2'b00, want.code} || last !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: char mismatch: expected data=%0d last=%b, got data=%0d last=%b",
                             $realtime, want.code, want.last, data, last);
            end
        endfunction

        function int outstanding();
            return pending_chars.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;     // [31:0] value
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;     // [5:0] ascii_char, [7:6] zero
    logic        m_tlast;     // last_char

    decimal_text_board board = new();

    bit idle_on   = 1'b1;     // random gaps on both sides; off for the tail
    int sink_hold = 0;        // long sink hold-off, counted down by the sink

    signed_int_to_decimal_ascii dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // Sink: ready changes on the falling edge. Random stalls, plus the long
    // hold-off when the stimulus asks for one.
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_hold > 0) begin
                m_tready  = 1'b0;
                sink_hold = sink_hold - 1;
            end else if (stall_left > 0) begin
                m_tready   = 1'b0;
                stall_left = stall_left - 1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_tready   = 1'b0;
                stall_left = $urandom_range(0, 2);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // Result beats are taken at the rising edge
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_char(m_tdata, m_tlast);
    end

    // Source gap, its length set by n; data is junk while valid is low
    task automatic source_gap(int n);
        @(negedge aclk);
        s_tvalid = 1'b0;
        s_tdata  = $urandom;
        repeat (n - 1) @(negedge aclk);
    endtask

    // Offer one integer and hold it until the block takes the beat
    task automatic offer_value(logic [31:0] v);
        if (idle_on && $urandom_range(0, 3) == 0)
            source_gap($urandom_range(1, 3));
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = v;
        do @(posedge aclk); while (!s_tready);
        board.note_value(v);
    endtask

    task automatic wait_text_drained();
        while (board.outstanding() != 0) @(posedge aclk);
    endtask

    // Random integer: a quarter fully random bits, the rest spread evenly over
    // digit counts 1..10 with random sign, some pinned to the decade edges.
    function automatic logic [31:0] draw_value();
        int     pick;
        int     ndig;
        int     neg;
        longint p;
        longint lo;
        longint hi;
        longint mag;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            return $urandom;
        neg  = $urandom_range(0, 1);
        ndig = $urandom_range(1, 10);
        p    = 1;
        repeat (ndig - 1) p = p * 10;
        lo = (ndig == 1) ? 0 : p;
        hi = p * 10 - 1;
        if (hi > 64'sd2147483647 + neg)
            hi = 64'sd2147483647 + neg;
        if (pick < 40)
            mag = $urandom_range(0, 1) ? lo : hi;
        else
            mag = lo + longint'({$urandom}) % (hi - lo + 1);
        return neg ? 32'(-mag) : 32'(mag);
    endfunction

    // Directed corners: zero, single digits, decade boundaries, the extremes
    // of the range including the most negative value, alternating bit patterns.
    logic [31:0] corner_values[] = '{
        32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99,
        32'd100, 32'd101, 32'd12345, -32'sd67890, 32'd999999999,
        32'd1000000000, -32'sd999999999, -32'sd1000000000, 32'd1999999999,
        32'h7FFFFFFF, 32'h80000001, 32'h80000000, 32'h55555555, 32'hAAAAAAAA
    };

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;

        foreach (corner_values[i])
            offer_value(corner_values[i]);

        for (int n = 0; n < 390; n++) begin
            // sink holds off while the source keeps offering: block backs up
            if (n == 80)
                sink_hold = 300;
            // source stops until every character so far has been seen
            if (n == 160) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
                wait_text_drained();
            end
            // tail of the run at full rate on both sides
            if (n == 330)
                idle_on = 1'b0;
            offer_value(draw_value());
        end
        @(negedge aclk);
        s_tvalid = 1'b0;

        wait_text_drained();
        repeat (60) @(posedge aclk);
        if (board.mismatches == 0 && board.outstanding() == 0)
            $display("[signed_int_to_decimal_ascii] OK");
        else
            $display("[signed_int_to_decimal_ascii] ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #2000000;
        $display("[signed_int_to_decimal_ascii] ERROR");
        $finish;
    end

endmodule
